FILE: hdl/sem_pkg.sv
// Shared types and constants for the session energy meter.
package sem_pkg;

   // Item opcodes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_END    = 2'd2;

   // Serial multiplier: 32 x 32 bits, one multiplier bit per cycle
   localparam int MUL_W = 32;
   localparam int MUL_CNT_W = $clog2(MUL_W);

   // Serial divider by a constant: one quotient bit per cycle
   localparam int DIV_W = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int MS_PER_S = 1000;
   localparam int REM_W = $clog2(MS_PER_S);

   // Status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } sem_unit_stat_type;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MULP  = 6'b000010,
      S_MULE  = 6'b000100,
      S_ACCUM = 6'b001000,
      S_DIV   = 6'b010000,
      S_EMIT  = 6'b100000
   } sem_state_type;

endpackage

FILE: hdl/sem_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module sem_serial_mul
   import sem_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MUL_W-1:0]     mcand,
   input  logic [MUL_W-1:0]     mplier,
   output sem_unit_stat_type    stat,
   output logic [2*MUL_W-1:0]   product
);

   logic [MUL_W-1:0]     mcand_ff;
   logic [2*MUL_W-1:0]   prod_ff, prod_in;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [MUL_W:0]       add_sum;

   // Add the multiplicand into the upper half when the low bit is set, then shift right
   always_comb begin
      add_sum = {1'b0, prod_ff[2*MUL_W-1:MUL_W]}
              + (prod_ff[0] ? {1'b0, mcand_ff} : {(MUL_W+1){1'b0}});
      prod_in = {add_sum, prod_ff[MUL_W-1:1]};
   end

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_W'(MUL_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand and product registers
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mcand;
         prod_ff  <= {{MUL_W{1'b0}}, mplier};
      end else if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = prod_ff;

endmodule

FILE: hdl/sem_div_ms.sv
// Bit-serial restoring divider of milliseconds by 1000, one quotient bit per cycle.
module sem_div_ms
   import sem_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   output sem_unit_stat_type    stat,
   output logic [DIV_W-1:0]     quotient
);

   logic [DIV_W-1:0]     work_ff;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [REM_W:0]       trial;
   logic                 fits;

   // Bring down the next dividend bit and subtract the divisor where it fits
   always_comb begin
      trial  = {rem_ff, work_ff[DIV_W-1]};
      fits   = trial >= (REM_W+1)'(MS_PER_S);
      rem_in = fits ? REM_W'(trial - (REM_W+1)'(MS_PER_S)) : trial[REM_W-1:0];
   end

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Dividend shifts out at the top while quotient bits shift in at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= dividend;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         work_ff <= {work_ff[DIV_W-2:0], fits};
         rem_ff  <= rem_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = work_ff;

endmodule

FILE: hdl/session_energy_meter.sv
// Top level of the per-session energy meter.
//
// Input items (req_) carry an opcode: bus sample, start session or end session.
// A sample in an active session adds V*|I|*dt (uW*ms) to a saturating session sum
// and tracks peak power and peak current. Closing a session (end, or start while a
// session is active, which closes it as failed) gives one result item (rsp_) with
// the session statistics and the lifetime totals after the update.
// Items that change only state are done in the idle state. An integrating sample runs
// the shared 32-step bit-serial multiplier twice, once for the power and once for
// the energy step, then the accumulate state adds into the sum. A closing item runs
// the 32-step serial division of the duration by 1000.
// req_stall is high while an item is at work; one item is processed at a time.
// The result sits in an output register; the next item is accepted while it waits.
// If a new result is ready while the old one is still stalled, the block holds
// until rsp_stall drops. Reset clears the session and all lifetime totals.
module session_energy_meter
   import sem_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [31:0]        req_time_ms,
   input  logic [15:0]        req_voltage_mv,
   input  logic signed [15:0] req_current_ma,
   input  logic               req_success,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_session_energy,
   output logic [22:0]        rsp_elapsed_sec,
   output logic [30:0]        rsp_peak_power_uw,
   output logic [15:0]        rsp_peak_current_ma,
   output logic               rsp_session_ok,
   output logic [31:0]        rsp_total_sessions,
   output logic [31:0]        rsp_total_ok_sessions,
   output logic [63:0]        rsp_total_energy
);

   sem_state_type state_ff, state_in;

   // Session and lifetime state
   logic        active_ff, active_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] last_ff, last_in;
   logic [63:0] energy_ff, energy_in;
   logic [30:0] max_pow_ff, max_pow_in;
   logic [15:0] max_cur_ff, max_cur_in;
   logic [31:0] closed_ff, closed_in;
   logic [31:0] good_ff, good_in;
   logic [63:0] life_ff, life_in;

   // Held item fields
   logic [31:0] time_ff, time_in;
   logic [31:0] dt_ff, dt_in;
   logic [30:0] pow_ff, pow_in;
   logic        ok_ff, ok_in;
   logic        reopen_ff, reopen_in;

   // Output register
   logic        out_vld_ff, out_vld_in;
   logic [63:0] o_energy_ff;
   logic [22:0] o_dur_ff;
   logic [30:0] o_pow_ff;
   logic [15:0] o_cur_ff;
   logic        o_ok_ff;
   logic [31:0] o_closed_ff;
   logic [31:0] o_good_ff;
   logic [63:0] o_life_ff;
   logic        out_load;

   // Arithmetic units
   logic                mul_start;
   logic [MUL_W-1:0]    mul_a, mul_b;
   sem_unit_stat_type   mul_stat;
   logic [2*MUL_W-1:0]  mul_prod;
   logic                div_start;
   sem_unit_stat_type   div_stat;
   logic [DIV_W-1:0]    div_quo;

   logic        accept;
   logic        out_free;
   logic [15:0] cur_u, imag;
   logic [31:0] step_dt;
   logic [64:0] e_sum;
   logic [64:0] l_sum;
   logic [63:0] l_new;

   assign accept   = req_valid && !req_stall;
   assign out_free = !out_vld_ff || !rsp_stall;

   // Current magnitude; the most negative code maps to 32768
   always_comb begin
      cur_u = $unsigned(req_current_ma);
      imag  = cur_u[15] ? 16'(~cur_u + 16'd1) : cur_u;
   end

   assign step_dt = req_time_ms - last_ff;

   // Saturating adds into the session and lifetime sums
   always_comb begin
      e_sum = {1'b0, energy_ff} + {1'b0, mul_prod};
      l_sum = {1'b0, life_ff} + {1'b0, energy_ff};
      l_new = l_sum[64] ? {64{1'b1}} : l_sum[63:0];
   end

   sem_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .stat    (mul_stat),
      .product (mul_prod)
   );

   sem_div_ms u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_time_ms - start_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // Sequence the item through the serial units and update state
   always_comb begin
      state_in   = state_ff;
      active_in  = active_ff;
      start_in   = start_ff;
      last_in    = last_ff;
      energy_in  = energy_ff;
      max_pow_in = max_pow_ff;
      max_cur_in = max_cur_ff;
      closed_in  = closed_ff;
      good_in    = good_ff;
      life_in    = life_ff;
      time_in    = time_ff;
      dt_in      = dt_ff;
      pow_in     = pow_ff;
      ok_in      = ok_ff;
      reopen_in  = reopen_ff;
      mul_start  = 1'b0;
      mul_a      = {{(MUL_W-16){1'b0}}, imag};
      mul_b      = {{(MUL_W-16){1'b0}}, req_voltage_mv};
      div_start  = 1'b0;
      out_load   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               time_in = req_time_ms;
               case (req_opcode)
                  OP_SAMPLE: begin
                     if (active_ff) begin
                        if (req_time_ms < start_ff) begin
                           last_in = '0;
                        end else if (last_ff == '0 || last_ff < start_ff) begin
                           last_in = req_time_ms;
                           if (imag > max_cur_ff) max_cur_in = imag;
                        end else if (step_dt == '0) begin
                           if (imag > max_cur_ff) max_cur_in = imag;
                        end else begin
                           last_in = req_time_ms;
                           dt_in   = step_dt;
                           if (imag != '0) begin
                              if (imag > max_cur_ff) max_cur_in = imag;
                              mul_start = 1'b1;
                              state_in  = S_MULP;
                           end
                        end
                     end
                  end
                  OP_START: begin
                     if (active_ff) begin
                        ok_in     = 1'b0;
                        reopen_in = 1'b1;
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end else begin
                        active_in  = 1'b1;
                        start_in   = req_time_ms;
                        last_in    = '0;
                        energy_in  = '0;
                        max_pow_in = '0;
                        max_cur_in = '0;
                     end
                  end
                  OP_END: begin
                     if (active_ff) begin
                        ok_in     = req_success;
                        reopen_in = 1'b0;
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MULP: begin
            // Power is ready: start the energy step p * dt
            if (mul_stat.done) begin
               pow_in    = mul_prod[30:0];
               mul_a     = {{(MUL_W-31){1'b0}}, mul_prod[30:0]};
               mul_b     = dt_ff;
               mul_start = 1'b1;
               state_in  = S_MULE;
            end
         end
         S_MULE: begin
            if (mul_stat.done) state_in = S_ACCUM;
         end
         S_ACCUM: begin
            energy_in = e_sum[64] ? {64{1'b1}} : e_sum[63:0];
            if (pow_ff > max_pow_ff) max_pow_in = pow_ff;
            state_in = S_IDLE;
         end
         S_DIV: begin
            if (div_stat.done) state_in = S_EMIT;
         end
         S_EMIT: begin
            // Hold until the output register is free, then close the session (and reopen it for a start)
            if (out_free) begin
               out_load  = 1'b1;
               closed_in = closed_ff + 32'd1;
               if (ok_ff) good_in = good_ff + 32'd1;
               life_in   = l_new;
               active_in = 1'b0;
               if (reopen_ff) begin
                  active_in  = 1'b1;
                  start_in   = time_ff;
                  last_in    = '0;
                  energy_in  = '0;
                  max_pow_in = '0;
                  max_cur_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   // Output valid: drop when taken, raise on a new result
   always_comb begin
      out_vld_in = out_vld_ff;
      if (out_vld_ff && !rsp_stall) out_vld_in = 1'b0;
      if (out_load) out_vld_in = 1'b1;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         active_ff  <= 1'b0;
         start_ff   <= '0;
         last_ff    <= '0;
         energy_ff  <= '0;
         max_pow_ff <= '0;
         max_cur_ff <= '0;
         closed_ff  <= '0;
         good_ff    <= '0;
         life_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         active_ff  <= active_in;
         start_ff   <= start_in;
         last_ff    <= last_in;
         energy_ff  <= energy_in;
         max_pow_ff <= max_pow_in;
         max_cur_ff <= max_cur_in;
         closed_ff  <= closed_in;
         good_ff    <= good_in;
         life_ff    <= life_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Held item fields
   always_ff @(posedge clock) begin
      time_ff   <= time_in;
      dt_ff     <= dt_in;
      pow_ff    <= pow_in;
      ok_ff     <= ok_in;
      reopen_ff <= reopen_in;
   end

   // Load the result item
   always_ff @(posedge clock) begin
      if (out_load) begin
         o_energy_ff <= energy_ff;
         o_dur_ff    <= div_quo[22:0];
         o_pow_ff    <= max_pow_ff;
         o_cur_ff    <= max_cur_ff;
         o_ok_ff     <= ok_ff;
         o_closed_ff <= closed_in;
         o_good_ff   <= good_in;
         o_life_ff   <= l_new;
      end
   end

   assign rsp_valid             = out_vld_ff;
   assign rsp_session_energy    = o_energy_ff;
   assign rsp_elapsed_sec       = o_dur_ff;
   assign rsp_peak_power_uw     = o_pow_ff;
   assign rsp_peak_current_ma   = o_cur_ff;
   assign rsp_session_ok        = o_ok_ff;
   assign rsp_total_sessions    = o_closed_ff;
   assign rsp_total_ok_sessions = o_good_ff;
   assign rsp_total_energy      = o_life_ff;

endmodule
